FILE: hdl/jmsp_pkg.sv
// Shared types and constants for the JPEG marker segment parser.
// No dependencies; compile first.
package jmsp_pkg;

    // Width of the running file offset counter (wraps at this width)
    localparam int OFFSET_BITS = 32;

    // Event codes on the result channel
    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_FRAME   = 3'd1;
    localparam logic [2:0] EV_RESTART = 3'd2;
    localparam logic [2:0] EV_END     = 3'd3;
    localparam logic [2:0] EV_NOSTART = 3'd4;
    localparam logic [2:0] EV_BADMARK = 3'd5;

    // One result transaction
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  marker_code;
        logic [15:0] segment_length;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
        logic [15:0] dri_interval;
        logic [31:0] byte_offset;
    } jmsp_result_t;

endpackage

FILE: hdl/jmsp_stream_if.sv
// Byte input channel of the marker segment parser: valid/ready plus payload.
// No dependencies.
interface jmsp_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

FILE: hdl/jmsp_report_if.sv
// Result channel of the marker segment parser: valid/ready plus event fields.
// No dependencies.
interface jmsp_report_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  marker_code;
    logic [15:0] segment_length;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [15:0] dri_interval;
    logic [31:0] byte_offset;

    modport source (
        output valid, output event_res, output marker_code, output segment_length,
        output frame_height, output frame_width, output dri_interval,
        output byte_offset, input ready
    );
    modport sink (
        input valid, input event_res, input marker_code, input segment_length,
        input frame_height, input frame_width, input dri_interval,
        input byte_offset, output ready
    );
endinterface

FILE: hdl/jmsp_core.sv
// Parser state machine: per-byte state update and result decode.
// Depends on jmsp_pkg.
module jmsp_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             data_byte,
    input  logic                   is_last,
    output logic                   res_valid,
    output jmsp_pkg::jmsp_result_t res
);
    import jmsp_pkg::*;

    localparam logic [3:0] PH_SOI0  = 4'd0;
    localparam logic [3:0] PH_SOI1  = 4'd1;
    localparam logic [3:0] PH_MARK0 = 4'd2;
    localparam logic [3:0] PH_MARK1 = 4'd3;
    localparam logic [3:0] PH_LENH  = 4'd4;
    localparam logic [3:0] PH_LENL  = 4'd5;
    localparam logic [3:0] PH_SOF   = 4'd6;
    localparam logic [3:0] PH_DRI   = 4'd7;
    localparam logic [3:0] PH_SKIP  = 4'd8;
    localparam logic [3:0] PH_STOP  = 4'd9;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_DRI    = 8'hDD;

    logic [3:0]             phase_reg, phase_next;
    logic [7:0]             marker_reg, marker_next;
    logic [15:0]            length_reg, length_next;
    logic [15:0]            skip_reg, skip_next;
    logic [2:0]             index_reg, index_next;
    logic [15:0]            height_reg, height_next;
    logic [7:0]             high_reg, high_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic [15:0] word_in;
    logic [15:0] skip_len;
    logic        skip_sel;

    assign word_in = {high_reg, data_byte};

    // Decode one byte: next state and optional result
    always_comb
    begin
        phase_next  = phase_reg;
        marker_next = marker_reg;
        length_next = length_reg;
        skip_next   = skip_reg;
        index_next  = index_reg;
        height_next = height_reg;
        high_next   = high_reg;
        offset_next = offset_reg + OFFSET_BITS'(1);
        skip_len    = '0;
        skip_sel    = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        res.byte_offset = 32'(offset_reg);

        unique case (phase_reg)
            PH_SOI0:
            begin
                if (data_byte == MK_PREFIX)
                begin
                    phase_next = PH_SOI1;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.event_res = EV_NOSTART;
                    phase_next    = PH_STOP;
                end
            end
            PH_SOI1:
            begin
                if (data_byte == MK_SOI)
                begin
                    phase_next = PH_MARK0;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.event_res = EV_NOSTART;
                    phase_next    = PH_STOP;
                end
            end
            PH_MARK0:
            begin
                if (data_byte == MK_PREFIX)
                begin
                    phase_next = PH_MARK1;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.event_res = EV_BADMARK;
                    phase_next    = PH_STOP;
                end
            end
            PH_MARK1:
            begin
                marker_next = data_byte;
                if (data_byte == MK_EOI)
                begin
                    res_valid       = 1'b1;
                    res.event_res   = EV_END;
                    res.marker_code = data_byte;
                    phase_next      = PH_STOP;
                end
                else
                begin
                    phase_next = PH_LENH;
                end
            end
            PH_LENH:
            begin
                high_next  = data_byte;
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                length_next        = word_in;
                res_valid          = 1'b1;
                res.event_res      = EV_HEADER;
                res.marker_code    = marker_reg;
                res.segment_length = word_in;
                index_next         = '0;
                if (marker_reg == MK_SOF0)
                begin
                    phase_next = PH_SOF;
                end
                else if (marker_reg == MK_DRI)
                begin
                    phase_next = PH_DRI;
                end
                else
                begin
                    skip_sel = 1'b1;
                    skip_len = (word_in >= 16'd2) ? word_in - 16'd2 : 16'd0;
                end
            end
            PH_SOF:
            begin
                // precision, height high/low, width high/low
                case (index_reg) inside
                    3'd1, 3'd3: high_next   = data_byte;
                    3'd2:       height_next = word_in;
                    3'd4:
                    begin
                        res_valid        = 1'b1;
                        res.event_res    = EV_FRAME;
                        res.marker_code  = marker_reg;
                        res.frame_height = height_reg;
                        res.frame_width  = word_in;
                        phase_next       = PH_STOP;
                    end
                    default: ;
                endcase
                index_next = index_reg + 3'd1;
            end
            PH_DRI:
            begin
                if (index_reg == 3'd0)
                begin
                    high_next  = data_byte;
                    index_next = 3'd1;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.event_res    = EV_RESTART;
                    res.marker_code  = marker_reg;
                    res.dri_interval = word_in;
                    index_next       = '0;
                    skip_sel         = 1'b1;
                    skip_len = (length_reg >= 16'd4) ? length_reg - 16'd4 : 16'd0;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_next == 16'd0)
                begin
                    phase_next = PH_MARK0;
                end
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        // Start a body skip, or go straight to the next marker when empty
        if (skip_sel)
        begin
            skip_next  = skip_len;
            phase_next = (skip_len == 16'd0) ? PH_MARK0 : PH_SKIP;
        end

        // Rearm after the final byte of the file
        if (is_last)
        begin
            phase_next  = PH_SOI0;
            marker_next = '0;
            length_next = '0;
            skip_next   = '0;
            index_next  = '0;
            height_next = '0;
            high_next   = '0;
            offset_next = '0;
        end
    end

    // Advance state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI0;
            marker_reg <= '0;
            length_reg <= '0;
            skip_reg   <= '0;
            index_reg  <= '0;
            height_reg <= '0;
            high_reg   <= '0;
            offset_reg <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            length_reg <= length_next;
            skip_reg   <= skip_next;
            index_reg  <= index_next;
            height_reg <= height_next;
            high_reg   <= high_next;
            offset_reg <= offset_next;
        end
    end

    // A body skip never sits on an empty count
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != 16'd0)
        else $error("skip phase with zero count");

    // Terminal events park the parser unless the byte rearms it
    a_stop_after_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid && !is_last &&
        (res.event_res == EV_END || res.event_res == EV_FRAME ||
         res.event_res == EV_NOSTART || res.event_res == EV_BADMARK)
        |=> phase_reg == PH_STOP)
        else $error("parser did not stop after terminal event");

    // Offset counts accepted bytes and clears on the last one
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> offset_reg ==
            ($past(is_last) ? '0 : $past(offset_reg) + OFFSET_BITS'(1)))
        else $error("byte offset out of step");

    // Stopped parser reports nothing
    a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_STOP |-> !res_valid)
        else $error("result while stopped");

endmodule

FILE: hdl/jmsp_out_reg.sv
// Result register between the parser and the result channel.
// Depends on jmsp_pkg.
module jmsp_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  jmsp_pkg::jmsp_result_t load_data,
    input  logic                   sink_ready,
    output logic                   in_ready,
    output logic                   valid,
    output jmsp_pkg::jmsp_result_t data
);
    import jmsp_pkg::*;

    logic         valid_reg, valid_next;
    jmsp_result_t data_reg;

    // Accept a new byte when the slot is empty or drains this cycle
    assign in_ready = !valid_reg || sink_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (sink_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the slot flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

    // Loading is only allowed when the slot can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> in_ready)
        else $error("result slot overwritten");

    // A pending result that is not taken survives the cycle
    a_keep_pending: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !sink_ready |=> valid_reg)
        else $error("pending result dropped");

    // A load always shows up as a valid result next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

FILE: hdl/jpeg_marker_segment_parser_unit.sv
// Top level of the JPEG marker segment parser.
// Depends on jmsp_pkg, jmsp_stream_if, jmsp_report_if, jmsp_core, jmsp_out_reg.
//
// Usage:
//   stream  - byte input channel (valid/ready). Each transaction carries one
//             file byte (data_byte) and is_last, which marks the final byte.
//   report  - result channel (valid/ready). A transaction carries one event:
//             segment header, frame size (SOF0), restart interval (DRI),
//             end of image, missing start marker or bad marker byte.
//   Each accepted byte gives zero or one result. A result appears on report
//   in the cycle after its byte is accepted and is held until taken.
//   Throughput: one byte per cycle while no result waits untaken; the parser
//   state update is combinational and the result register frees as it drains.
//   Receiver stall: while a result waits untaken, stream.ready drops, so no
//   byte is taken until the result register can accept the next result.
//   Reset (rst_n low) returns the parser to wait for the start marker and
//   empties the result register. After a terminal event the parser ignores
//   bytes; the byte marked is_last rearms it, offset counter included.
module jpeg_marker_segment_parser_unit (
    input logic           clk,
    input logic           rst_n,
    jmsp_stream_if.sink   stream,
    jmsp_report_if.source report
);
    import jmsp_pkg::*;

    logic         take;
    logic         in_ready;
    logic         res_valid;
    jmsp_result_t res;
    jmsp_result_t out_data;

    assign stream.ready = in_ready;
    assign take         = stream.valid && in_ready;

    jmsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (stream.data_byte),
        .is_last   (stream.is_last),
        .res_valid (res_valid),
        .res       (res)
    );

    jmsp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && res_valid),
        .load_data  (res),
        .sink_ready (report.ready),
        .in_ready   (in_ready),
        .valid      (report.valid),
        .data       (out_data)
    );

    // Drive the result channel fields
    assign report.event_res      = out_data.event_res;
    assign report.marker_code    = out_data.marker_code;
    assign report.segment_length = out_data.segment_length;
    assign report.frame_height   = out_data.frame_height;
    assign report.frame_width    = out_data.frame_width;
    assign report.dri_interval   = out_data.dri_interval;
    assign report.byte_offset    = out_data.byte_offset;

endmodule

FILE: sim/jpeg_marker_segment_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for jpeg_marker_segment_parser_unit: feeds JPEG-like byte files and
// checks each reported event against a built-in marker parser model.
// Depends on jmsp_pkg, jmsp_stream_if, jmsp_report_if and the parser RTL.
module jpeg_marker_segment_parser_unit_tb;
    import jmsp_pkg::*;

    // Marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_DRI    = 8'hDD;

    localparam int RANDOM_BYTES = 1900;

    typedef enum logic [3:0] {
        P_SOI0, P_SOI1, P_MARK0, P_MARK1, P_LENH, P_LENL, P_SOF, P_DRI, P_SKIP, P_STOP
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    logic clk;
    logic rst_n;

    jmsp_stream_if byte_if ();
    jmsp_report_if event_if ();

    jpeg_marker_segment_parser_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_if.sink),
        .report (event_if.source)
    );

    // Parser model state
    parse_phase_t           ph;
    logic [7:0]             cur_marker;
    logic [15:0]            seg_len;
    logic [15:0]            skip_left;
    logic [3:0]             hdr_idx;
    logic [15:0]            height_hold;
    logic [7:0]             hi_byte;
    logic [OFFSET_BITS-1:0] file_pos;

    file_byte_t   bytes_to_send[$];
    jmsp_result_t events_due[$];
    file_byte_t   next_byte;
    jmsp_result_t seen_ev;
    jmsp_result_t want_ev;

    int  total_bytes;
    int  bytes_taken;
    int  live_bytes;
    int  mismatches;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  byte_taken;

    // Return the parser model to its post-reset state
    task automatic rearm_parser();
        ph          = P_SOI0;
        cur_marker  = '0;
        seg_len     = '0;
        skip_left   = '0;
        hdr_idx     = '0;
        height_hold = '0;
        hi_byte     = '0;
        file_pos    = '0;
    endtask

    // Advance the parser model by one byte and queue the event it raises
    task automatic parse_byte(input logic [7:0] b, input logic last);
        jmsp_result_t ev;
        bit           fire;
        ev             = '0;
        fire           = 1'b0;
        ev.byte_offset = 32'(file_pos);
        case (ph) inside
            P_SOI0, P_SOI1:
            begin
                if (ph == P_SOI0 && b == MARK_PREFIX)
                    ph = P_SOI1;
                else if (ph == P_SOI1 && b == MARK_SOI)
                    ph = P_MARK0;
                else
                begin
                    ev.event_res = EV_NOSTART;
                    fire         = 1'b1;
                    ph           = P_STOP;
                end
            end
            P_MARK0:
            begin
                if (b == MARK_PREFIX)
                    ph = P_MARK1;
                else
                begin
                    ev.event_res = EV_BADMARK;
                    fire         = 1'b1;
                    ph           = P_STOP;
                end
            end
            P_MARK1:
            begin
                cur_marker = b;
                if (b == MARK_EOI)
                begin
                    ev.event_res   = EV_END;
                    ev.marker_code = b;
                    fire           = 1'b1;
                    ph             = P_STOP;
                end
                else
                    ph = P_LENH;
            end
            P_LENH:
            begin
                hi_byte = b;
                ph      = P_LENL;
            end
            P_LENL:
            begin
                seg_len           = {hi_byte, b};
                ev.event_res      = EV_HEADER;
                ev.marker_code    = cur_marker;
                ev.segment_length = seg_len;
                fire              = 1'b1;
                hdr_idx           = '0;
                if (cur_marker == MARK_SOF0)
                    ph = P_SOF;
                else if (cur_marker == MARK_DRI)
                    ph = P_DRI;
                else
                begin
                    skip_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                    ph        = (skip_left == '0) ? P_MARK0 : P_SKIP;
                end
            end
            P_SOF:
            begin
                // precision, height high/low, width high/low
                if (hdr_idx == 4'd1 || hdr_idx == 4'd3)
                    hi_byte = b;
                else if (hdr_idx == 4'd2)
                    height_hold = {hi_byte, b};
                else if (hdr_idx == 4'd4)
                begin
                    ev.event_res    = EV_FRAME;
                    ev.marker_code  = cur_marker;
                    ev.frame_height = height_hold;
                    ev.frame_width  = {hi_byte, b};
                    fire            = 1'b1;
                    ph              = P_STOP;
                end
                hdr_idx = hdr_idx + 4'd1;
            end
            P_DRI:
            begin
                if (hdr_idx == '0)
                begin
                    hi_byte = b;
                    hdr_idx = 4'd1;
                end
                else
                begin
                    ev.event_res    = EV_RESTART;
                    ev.marker_code  = cur_marker;
                    ev.dri_interval = {hi_byte, b};
                    fire            = 1'b1;
                    hdr_idx         = '0;
                    skip_left = (seg_len >= 16'd4) ? seg_len - 16'd4 : 16'd0;
                    ph        = (skip_left == '0) ? P_MARK0 : P_SKIP;
                end
            end
            P_SKIP:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == '0)
                    ph = P_MARK0;
            end
            default:
                ph = P_STOP;
        endcase
        file_pos = file_pos + OFFSET_BITS'(1);
        if (fire)
            events_due.push_back(ev);
        if (last)
            rearm_parser();
    endtask

    // Append one file to the send queue, flagging its final byte
    task automatic queue_file(input logic [7:0] fb[$]);
        file_byte_t item;
        foreach (fb[i])
        begin
            item.data = fb[i];
            item.last = (i == fb.size() - 1);
            bytes_to_send.push_back(item);
        end
    endtask

    // Pick a 16-bit field value, biased toward the extremes
    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one random file: mostly well-formed segment chains, some noise
    task automatic build_random_file();
        logic [7:0]  fb[$];
        logic [7:0]  code;
        logic [15:0] word;
        int          nseg;
        int          kind;
        int          len;
        int          cut;
        bit          done;
        fb   = {};
        done = 1'b0;
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(1, 5)) fb.push_back(8'($urandom));
        end
        else
        begin
            fb.push_back(($urandom_range(99) < 3) ? 8'($urandom) : MARK_PREFIX);
            fb.push_back(($urandom_range(99) < 3) ? 8'($urandom) : MARK_SOI);
            nseg = $urandom_range(1, 6);
            for (int s = 0; s < nseg && !done; s++)
            begin
                kind = $urandom_range(99);
                if (kind < 4)
                begin
                    // non-FF byte where a marker must begin
                    fb.push_back(8'($urandom_range(254)));
                    done = 1'b1;
                end
                else if (kind < 12)
                begin
                    fb.push_back(MARK_PREFIX);
                    fb.push_back(MARK_EOI);
                    done = 1'b1;
                end
                else if (kind < 22)
                begin
                    // frame header: length ignored, five body bytes read
                    fb.push_back(MARK_PREFIX);
                    fb.push_back(MARK_SOF0);
                    word = pick_word();
                    fb.push_back(word[15:8]);
                    fb.push_back(word[7:0]);
                    fb.push_back(8'($urandom));
                    repeat (2)
                    begin
                        word = pick_word();
                        fb.push_back(word[15:8]);
                        fb.push_back(word[7:0]);
                    end
                    done = 1'b1;
                end
                else if (kind < 38)
                begin
                    fb.push_back(MARK_PREFIX);
                    fb.push_back(MARK_DRI);
                    len = $urandom_range(0, 10);
                    fb.push_back(8'(len >> 8));
                    fb.push_back(8'(len));
                    word = pick_word();
                    fb.push_back(word[15:8]);
                    fb.push_back(word[7:0]);
                    for (int k = 4; k < len; k++)
                        fb.push_back(8'($urandom));
                end
                else
                begin
                    code = 8'($urandom);
                    if (code == MARK_SOF0 || code == MARK_DRI || code == MARK_EOI)
                        code = MARK_SOS;
                    fb.push_back(MARK_PREFIX);
                    fb.push_back(code);
                    if ($urandom_range(99) < 10)
                    begin
                        // long segment: cut the file short inside the body
                        word = pick_word();
                        fb.push_back(word[15:8]);
                        fb.push_back(word[7:0]);
                        repeat ($urandom_range(0, 4)) fb.push_back(8'($urandom));
                        done = 1'b1;
                    end
                    else
                    begin
                        len = $urandom_range(0, 14);
                        fb.push_back(8'(len >> 8));
                        fb.push_back(8'(len));
                        for (int k = 2; k < len; k++)
                            fb.push_back(8'($urandom));
                    end
                end
            end
            if (!done && $urandom_range(1) == 1)
            begin
                fb.push_back(MARK_PREFIX);
                fb.push_back(MARK_EOI);
                done = 1'b1;
            end
        end
        // Truncate some files at a random point
        if ($urandom_range(99) < 8 && fb.size() > 1)
        begin
            cut = $urandom_range(1, fb.size() - 1);
            fb  = fb[0:cut-1];
        end
        live_bytes += fb.size();
        // Pad stopped files with bytes the parser should ignore
        if (done)
            repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom));
        queue_file(fb);
    endtask

    // Compare one event field
    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, seen);
            mismatches++;
        end
    endtask

    // Clock generation
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Drive bytes from the send queue, advance on each accepted transaction
    always @(negedge clk)
    begin
        if (bytes_taken < total_bytes / 3)
        begin
            send_idle_pct = 11;
            recv_idle_pct = 55;
        end
        else if (bytes_taken < (2 * total_bytes) / 3)
        begin
            send_idle_pct = 55;
            recv_idle_pct = 11;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (rst_n && (!byte_if.valid || byte_taken))
        begin
            if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_byte          = bytes_to_send.pop_front();
                byte_if.valid     <= 1'b1;
                byte_if.data_byte <= next_byte.data;
                byte_if.is_last   <= next_byte.last;
            end
            else
                byte_if.valid <= 1'b0;
        end
        event_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Predict on accepted bytes, check accepted events
    always @(posedge clk)
    begin
        byte_taken = 1'b0;
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                byte_taken = 1'b1;
                parse_byte(byte_if.data_byte, byte_if.is_last);
                bytes_taken++;
            end
            if (event_if.valid && event_if.ready)
            begin
                seen_ev.event_res      = event_if.event_res;
                seen_ev.marker_code    = event_if.marker_code;
                seen_ev.segment_length = event_if.segment_length;
                seen_ev.frame_height   = event_if.frame_height;
                seen_ev.frame_width    = event_if.frame_width;
                seen_ev.dri_interval   = event_if.dri_interval;
                seen_ev.byte_offset    = event_if.byte_offset;
                if (events_due.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, got %p", $time, seen_ev);
                    mismatches++;
                end
                else
                begin
                    want_ev = events_due.pop_front();
                    check_field("event_res", 32'(want_ev.event_res), 32'(seen_ev.event_res));
                    check_field("marker_code", 32'(want_ev.marker_code),
                                32'(seen_ev.marker_code));
                    check_field("segment_length", 32'(want_ev.segment_length),
                                32'(seen_ev.segment_length));
                    check_field("frame_height", 32'(want_ev.frame_height),
                                32'(seen_ev.frame_height));
                    check_field("frame_width", 32'(want_ev.frame_width),
                                32'(seen_ev.frame_width));
                    check_field("dri_interval", 32'(want_ev.dri_interval),
                                32'(seen_ev.dri_interval));
                    check_field("byte_offset", want_ev.byte_offset, seen_ev.byte_offset);
                end
            end
        end
    end

    // Build stimulus, reset, then wait for the drain
    initial
    begin
        logic [7:0] fb[$];
        rst_n              = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        byte_if.is_last    = 1'b0;
        event_if.ready     = 1'b0;
        bytes_taken        = 0;
        total_bytes        = 0;
        live_bytes         = 0;
        mismatches         = 0;
        byte_taken         = 1'b0;
        rearm_parser();

        // Missing start on the first byte, then on the second
        fb = {8'h00};
        queue_file(fb);
        fb = {MARK_PREFIX, 8'h00};
        queue_file(fb);
        // Bad marker, then a byte ignored while stopped
        fb = {MARK_PREFIX, MARK_SOI, 8'h12, MARK_PREFIX};
        queue_file(fb);
        // End of image on the last byte
        fb = {MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_EOI};
        queue_file(fb);
        // Short length on an FF code, short restart segment, frame with zero length
        fb = {MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_PREFIX, 8'h00, 8'h01,
              MARK_PREFIX, MARK_DRI, 8'h00, 8'h02, 8'h12, 8'h34,
              MARK_PREFIX, MARK_SOF0, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00};
        queue_file(fb);

        while (live_bytes < RANDOM_BYTES)
            build_random_file();
        total_bytes = bytes_to_send.size();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < total_bytes)
            @(negedge clk);
        while (events_due.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Bound the run
    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d events still due", $time, events_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/jmsp_pkg.sv
hdl/jmsp_stream_if.sv
hdl/jmsp_report_if.sv
hdl/jmsp_core.sv
hdl/jmsp_out_reg.sv
hdl/jpeg_marker_segment_parser_unit.sv
sim/jpeg_marker_segment_parser_unit_tb.sv
